@@ rtl/led_ring_status_renderer_assert.svh @@
// Assertion macros for the LED status ring renderer checkers.
// Expects clk and rst_n in the scope of each use.
`ifndef LED_RING_STATUS_RENDERER_ASSERT_SVH
`define LED_RING_STATUS_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LRSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define LRSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lrsr_pkg.sv @@
// Package for the LED status ring renderer: beat types, codes, constants
// and small per-LED helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrsr_pkg;

  localparam int unsigned RING_LEDS     = 12;
  localparam logic [31:0] FLASH_TIME_MS = 32'd600;
  localparam logic [3:0]  LAST_LED      = 4'd11;

  localparam logic [23:0] RGB_BLACK     = 24'h000000;
  localparam logic [23:0] RGB_HOUR      = 24'hFF0000;
  localparam logic [23:0] RGB_MINUTE    = 24'h008000;
  localparam logic [23:0] RGB_SHARED    = 24'hFFFF00;

  localparam logic [7:0]  RST_BRIGHTNESS = 8'd40;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_WAKE = 1'b1;

  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_MOTION = 2'd1;
  localparam logic [1:0] CAUSE_TIMER  = 2'd2;
  localparam logic [1:0] CAUSE_RADIO  = 2'd3;

  localparam logic [3:0] REG_BRIGHTNESS = 4'd0;
  localparam logic [3:0] REG_ALARM_RGB  = 4'd1;
  localparam logic [3:0] REG_ALARM_ON   = 4'd2;
  localparam logic [3:0] REG_ALARM_OFF  = 4'd3;
  localparam logic [3:0] REG_GRACE_RGB  = 4'd4;
  localparam logic [3:0] REG_MOTION_RGB = 4'd5;
  localparam logic [3:0] REG_TIMER_RGB  = 4'd6;
  localparam logic [3:0] REG_RADIO_RGB  = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_SOLID,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    FR_SOLID,
    FR_BAR,
    FR_CLOCK
  } frame_kind_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic [1:0]  wake_cause;
    logic        unpaired;
    logic        enforcing;
    logic        cond_ok;
    logic        grace_open;
    logic        burst_on;
    logic [31:0] output_since;
    logic [7:0]  grace_progress;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
    logic       last_led;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [23:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [7:0]  global_brightness;
    logic [23:0] alarm_color;
    logic [15:0] alarm_on_time;
    logic [15:0] alarm_off_time;
    logic [23:0] grace_color;
    logic [23:0] motion_color;
    logic [23:0] timer_color;
    logic [23:0] radio_color;
  } cfg_regs_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] rem;
  } div_rsp_t;

  // Nonzero channel c becomes (c*48 >> 8) + 1, i.e. (c*3 >> 4) + 1.
  function automatic logic [23:0] scale_video(input logic [23:0] c);
    logic [23:0] r;
    logic [9:0]  p;
    for (int k = 0; k < 3; k++) begin
      p = {2'b00, c[k*8 +: 8]} * 10'd3;
      r[k*8 +: 8] = (c[k*8 +: 8] == 8'd0) ? 8'd0 : (8'(p >> 4) + 8'd1);
    end
    return r;
  endfunction

  // LED of the hour hand: 11 - hour % 12.
  function automatic logic [3:0] hour_led(input logic [4:0] hour);
    logic [4:0] h;
    if (hour >= 5'd24) begin
      h = hour - 5'd24;
    end else if (hour >= 5'd12) begin
      h = hour - 5'd12;
    end else begin
      h = hour;
    end
    return LAST_LED - h[3:0];
  endfunction

  // LED of the minute hand: 11 - min(minute / 5, 11); minute/5 = minute*13 >> 6 here.
  function automatic logic [3:0] minute_led(input logic [5:0] minute);
    logic [9:0] p;
    logic [3:0] b;
    p = {4'b0000, minute} * 10'd13;
    b = p[9:6];
    if (b > LAST_LED) begin
      b = LAST_LED;
    end
    return LAST_LED - b;
  endfunction

  // Bar length 1 + progress*11/255; x/255 = (x + (x >> 8) + 1) >> 8 for this range.
  function automatic logic [3:0] bar_lit(input logic [7:0] prog);
    logic [11:0] prod;
    logic [11:0] sum;
    prod = {4'b0000, prog} * 12'd11;
    sum  = prod + (prod >> 8) + 12'd1;
    return sum[11:8] + 4'd1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lrsr_if.sv @@
// Handshake interfaces for the renderer's input, result and config channels.
// Depends on lrsr_pkg for the beat types.
`timescale 1ns / 1ps
`default_nettype none

interface lrsr_in_if;
  logic               valid;
  logic               ready;
  lrsr_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lrsr_out_if;
  logic                valid;
  logic                ready;
  lrsr_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lrsr_cfg_if;
  logic                 valid;
  logic                 ready;
  lrsr_pkg::cfg_write_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/lrsr_mod_unit.sv @@
// Serial remainder unit: one quotient bit per cycle.
// Depends on lrsr_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module lrsr_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  lrsr_pkg::div_req_t req,
  output lrsr_pkg::div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [16:0] div_r, div_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [17:0] trial;
  logic [17:0] diff;

  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // restoring step: keep the difference when the trial fits
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[16:0] : trial[16:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/lrsr_seq.sv @@
// Sequencer: display priority, flash and dedup state, frame generation.
// Depends on lrsr_pkg; drives the remainder unit through div_req_t.
`timescale 1ns / 1ps
`default_nettype none

module lrsr_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lrsr_pkg::in_item_t  in_item,
  output logic                in_ready,
  input  lrsr_pkg::cfg_regs_t cfg,
  input  logic                cfg_wr,
  output lrsr_pkg::div_req_t  div_req,
  input  lrsr_pkg::div_rsp_t  div_rsp,
  output logic                beat_valid,
  output lrsr_pkg::out_item_t beat,
  input  logic                beat_take
);

  lrsr_pkg::state_t      state_r, state_nxt;
  lrsr_pkg::in_item_t    item_r, item_nxt;
  lrsr_pkg::frame_kind_t kind_r, kind_nxt;
  logic [1:0]  flash_cause_r, flash_cause_nxt;
  logic [31:0] flash_start_r, flash_start_nxt;
  logic [5:0]  shown_minute_r, shown_minute_nxt;
  logic        shown_valid_r, shown_valid_nxt;
  logic        clock_dirty_r, clock_dirty_nxt;
  logic [23:0] cached_color_r, cached_color_nxt;
  logic [7:0]  cached_bright_r, cached_bright_nxt;
  logic        solid_valid_r, solid_valid_nxt;
  logic [3:0]  cached_bar_r, cached_bar_nxt;
  logic        bar_valid_r, bar_valid_nxt;
  logic [23:0] color_r, color_nxt;
  logic [3:0]  lit_r, lit_nxt;
  logic [3:0]  hp_r, hp_nxt;
  logic [3:0]  mp_r, mp_nxt;
  logic [3:0]  led_r, led_nxt;

  logic [31:0] flash_age;
  logic [1:0]  flash_eff;
  logic [3:0]  lit_now;
  logic [23:0] flash_rgb;
  logic [23:0] led_rgb;

  assign flash_age = item_r.now_ms - flash_start_r;
  assign flash_eff = (flash_cause_r != lrsr_pkg::CAUSE_NONE &&
                      flash_age >= lrsr_pkg::FLASH_TIME_MS) ? lrsr_pkg::CAUSE_NONE
                                                            : flash_cause_r;
  assign lit_now   = lrsr_pkg::bar_lit(item_r.grace_progress);

  always_comb begin
    case (flash_eff)
      lrsr_pkg::CAUSE_MOTION: flash_rgb = cfg.motion_color;
      lrsr_pkg::CAUSE_TIMER:  flash_rgb = cfg.timer_color;
      default:                flash_rgb = cfg.radio_color;
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    item_nxt          = item_r;
    kind_nxt          = kind_r;
    flash_cause_nxt   = flash_cause_r;
    flash_start_nxt   = flash_start_r;
    shown_minute_nxt  = shown_minute_r;
    shown_valid_nxt   = shown_valid_r;
    clock_dirty_nxt   = clock_dirty_r;
    cached_color_nxt  = cached_color_r;
    cached_bright_nxt = cached_bright_r;
    solid_valid_nxt   = solid_valid_r;
    cached_bar_nxt    = cached_bar_r;
    bar_valid_nxt     = bar_valid_r;
    color_nxt         = color_r;
    lit_nxt           = lit_r;
    hp_nxt            = hp_r;
    mp_nxt            = mp_r;
    led_nxt           = led_r;
    in_ready          = 1'b0;
    beat_valid        = 1'b0;
    div_req.start     = 1'b0;
    div_req.dividend  = item_r.now_ms - item_r.output_since;
    div_req.divisor   = {1'b0, cfg.alarm_on_time} + {1'b0, cfg.alarm_off_time};

    case (state_r)
      lrsr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.cmd == lrsr_pkg::CMD_WAKE) begin
            if (in_item.wake_cause != lrsr_pkg::CAUSE_NONE) begin
              flash_cause_nxt = in_item.wake_cause;
              flash_start_nxt = in_item.now_ms;
            end
          end else begin
            item_nxt  = in_item;
            state_nxt = lrsr_pkg::ST_DECIDE;
          end
        end
      end

      lrsr_pkg::ST_DECIDE: begin
        flash_cause_nxt = flash_eff;
        clock_dirty_nxt = 1'b1;
        if (item_r.unpaired) begin
          color_nxt = lrsr_pkg::RGB_BLACK;
          state_nxt = lrsr_pkg::ST_SOLID;
        end else if (item_r.enforcing && !item_r.cond_ok) begin
          if (!item_r.burst_on) begin
            color_nxt = lrsr_pkg::scale_video(cfg.alarm_color);
            state_nxt = lrsr_pkg::ST_SOLID;
          end else if (cfg.alarm_on_time != 16'd0 && cfg.alarm_off_time != 16'd0) begin
            div_req.start = 1'b1;
            state_nxt     = lrsr_pkg::ST_DIVIDE;
          end else begin
            color_nxt = cfg.alarm_color;
            state_nxt = lrsr_pkg::ST_SOLID;
          end
        end else if (item_r.enforcing && item_r.grace_open) begin
          if (bar_valid_r && cached_bar_r == lit_now &&
              cached_color_r == cfg.grace_color &&
              cached_bright_r == cfg.global_brightness) begin
            state_nxt = lrsr_pkg::ST_IDLE;
          end else begin
            cached_bar_nxt    = lit_now;
            bar_valid_nxt     = 1'b1;
            cached_color_nxt  = cfg.grace_color;
            cached_bright_nxt = cfg.global_brightness;
            solid_valid_nxt   = 1'b0;
            kind_nxt          = lrsr_pkg::FR_BAR;
            color_nxt         = cfg.grace_color;
            lit_nxt           = lit_now;
            led_nxt           = '0;
            state_nxt         = lrsr_pkg::ST_EMIT;
          end
        end else if (flash_eff != lrsr_pkg::CAUSE_NONE) begin
          color_nxt = flash_rgb;
          state_nxt = lrsr_pkg::ST_SOLID;
        end else if (item_r.enforcing) begin
          state_nxt = lrsr_pkg::ST_IDLE;
        end else if (clock_dirty_r || !shown_valid_r ||
                     item_r.minute_of_hour != shown_minute_r) begin
          clock_dirty_nxt  = 1'b0;
          shown_minute_nxt = item_r.minute_of_hour;
          shown_valid_nxt  = 1'b1;
          solid_valid_nxt  = 1'b0;
          bar_valid_nxt    = 1'b0;
          kind_nxt         = lrsr_pkg::FR_CLOCK;
          hp_nxt           = lrsr_pkg::hour_led(item_r.hour_of_day);
          mp_nxt           = lrsr_pkg::minute_led(item_r.minute_of_hour);
          led_nxt          = '0;
          state_nxt        = lrsr_pkg::ST_EMIT;
        end else begin
          clock_dirty_nxt = clock_dirty_r;
          state_nxt       = lrsr_pkg::ST_IDLE;
        end
      end

      lrsr_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          // dark once the blink phase reaches the on time
          color_nxt = (div_rsp.rem >= {1'b0, cfg.alarm_on_time}) ? lrsr_pkg::RGB_BLACK
                                                                 : cfg.alarm_color;
          state_nxt = lrsr_pkg::ST_SOLID;
        end
      end

      lrsr_pkg::ST_SOLID: begin
        if (solid_valid_r && cached_color_r == color_r &&
            cached_bright_r == cfg.global_brightness) begin
          state_nxt = lrsr_pkg::ST_IDLE;
        end else begin
          cached_color_nxt  = color_r;
          cached_bright_nxt = cfg.global_brightness;
          solid_valid_nxt   = 1'b1;
          bar_valid_nxt     = 1'b0;
          kind_nxt          = lrsr_pkg::FR_SOLID;
          led_nxt           = '0;
          state_nxt         = lrsr_pkg::ST_EMIT;
        end
      end

      lrsr_pkg::ST_EMIT: begin
        beat_valid = 1'b1;
        if (beat_take) begin
          led_nxt = led_r + 4'd1;
          if (led_r == lrsr_pkg::LAST_LED) begin
            state_nxt = lrsr_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = lrsr_pkg::ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      solid_valid_nxt = 1'b0;
    end
  end

  // colour of the LED currently on the output side
  always_comb begin
    case (kind_r)
      lrsr_pkg::FR_SOLID: led_rgb = color_r;
      lrsr_pkg::FR_BAR: begin
        led_rgb = (led_r >= 4'(lrsr_pkg::RING_LEDS) - lit_r) ? color_r
                                                             : lrsr_pkg::RGB_BLACK;
      end
      lrsr_pkg::FR_CLOCK: begin
        if (led_r == hp_r && led_r == mp_r) begin
          led_rgb = lrsr_pkg::RGB_SHARED;
        end else if (led_r == hp_r) begin
          led_rgb = lrsr_pkg::RGB_HOUR;
        end else if (led_r == mp_r) begin
          led_rgb = lrsr_pkg::RGB_MINUTE;
        end else begin
          led_rgb = lrsr_pkg::RGB_BLACK;
        end
      end
      default: led_rgb = lrsr_pkg::RGB_BLACK;
    endcase
  end

  assign beat.led_index  = led_r;
  assign beat.red        = led_rgb[23:16];
  assign beat.green      = led_rgb[15:8];
  assign beat.blue       = led_rgb[7:0];
  assign beat.brightness = cfg.global_brightness;
  assign beat.last_led   = (led_r == lrsr_pkg::LAST_LED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= lrsr_pkg::ST_IDLE;
      flash_cause_r   <= lrsr_pkg::CAUSE_NONE;
      flash_start_r   <= '0;
      shown_minute_r  <= '0;
      shown_valid_r   <= 1'b0;
      clock_dirty_r   <= 1'b1;
      cached_color_r  <= lrsr_pkg::RGB_BLACK;
      cached_bright_r <= lrsr_pkg::RST_BRIGHTNESS;
      solid_valid_r   <= 1'b1;
      cached_bar_r    <= '0;
      bar_valid_r     <= 1'b0;
      led_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      flash_cause_r   <= flash_cause_nxt;
      flash_start_r   <= flash_start_nxt;
      shown_minute_r  <= shown_minute_nxt;
      shown_valid_r   <= shown_valid_nxt;
      clock_dirty_r   <= clock_dirty_nxt;
      cached_color_r  <= cached_color_nxt;
      cached_bright_r <= cached_bright_nxt;
      solid_valid_r   <= solid_valid_nxt;
      cached_bar_r    <= cached_bar_nxt;
      bar_valid_r     <= bar_valid_nxt;
      led_r           <= led_nxt;
    end
    item_r  <= item_nxt;
    kind_r  <= kind_nxt;
    color_r <= color_nxt;
    lit_r   <= lit_nxt;
    hp_r    <= hp_nxt;
    mp_r    <= mp_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/led_ring_status_renderer.sv @@
// LED status ring renderer, top level: config registers, output register,
// sequencer and remainder unit. Depends on lrsr_pkg, lrsr_if.sv,
// lrsr_mod_unit and lrsr_seq.
//
// A wake note is taken and produces no beat. A status tick is taken, the
// display is picked, while the alarm blinks the serial remainder unit works
// out the blink phase, one bit of the 32-bit elapsed time per cycle, and a
// solid colour is checked against the solid-colour cache; a repaint then
// sends 12 LED beats, index 0 to 11, one per cycle while the sink takes
// them. in_if.ready stays low from a tick until the sequencer is idle again,
// for a repaint until its last beat sits in the output register; sink stalls
// keep it low longer. Config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module led_ring_status_renderer (
  input  logic       clk,
  input  logic       rst_n,
  lrsr_in_if.sink    in_if,
  lrsr_out_if.source out_if,
  lrsr_cfg_if.sink   cfg_if
);

  lrsr_pkg::cfg_regs_t cfg_r, cfg_nxt;
  logic                cfg_wr;
  lrsr_pkg::div_req_t  div_req;
  lrsr_pkg::div_rsp_t  div_rsp;
  logic                beat_valid;
  logic                beat_take;
  lrsr_pkg::out_item_t beat;
  logic                out_valid_r, out_valid_nxt;
  lrsr_pkg::out_item_t out_item_r, out_item_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr = cfg_if.valid &&
                  (cfg_if.payload.index inside {[lrsr_pkg::REG_BRIGHTNESS:
                                                 lrsr_pkg::REG_RADIO_RGB]});

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.payload.index)
        lrsr_pkg::REG_BRIGHTNESS: cfg_nxt.global_brightness = cfg_if.payload.data[7:0];
        lrsr_pkg::REG_ALARM_RGB:  cfg_nxt.alarm_color       = cfg_if.payload.data;
        lrsr_pkg::REG_ALARM_ON:   cfg_nxt.alarm_on_time     = cfg_if.payload.data[15:0];
        lrsr_pkg::REG_ALARM_OFF:  cfg_nxt.alarm_off_time    = cfg_if.payload.data[15:0];
        lrsr_pkg::REG_GRACE_RGB:  cfg_nxt.grace_color       = cfg_if.payload.data;
        lrsr_pkg::REG_MOTION_RGB: cfg_nxt.motion_color      = cfg_if.payload.data;
        lrsr_pkg::REG_TIMER_RGB:  cfg_nxt.timer_color       = cfg_if.payload.data;
        lrsr_pkg::REG_RADIO_RGB:  cfg_nxt.radio_color       = cfg_if.payload.data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.global_brightness <= lrsr_pkg::RST_BRIGHTNESS;
      cfg_r.alarm_color       <= 24'hFF0000;
      cfg_r.alarm_on_time     <= 16'd250;
      cfg_r.alarm_off_time    <= 16'd250;
      cfg_r.grace_color       <= 24'hFFC800;
      cfg_r.motion_color      <= 24'h00FF00;
      cfg_r.timer_color       <= 24'h00B4FF;
      cfg_r.radio_color       <= 24'hFFFFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lrsr_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lrsr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_item    (in_if.payload),
    .in_ready   (in_if.ready),
    .cfg        (cfg_r),
    .cfg_wr     (cfg_wr),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  // output register: load when empty or when the held beat leaves
  assign beat_take = !out_valid_r || out_if.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (beat_valid && beat_take) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = beat;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

endmodule

`default_nettype wire

@@ rtl/lrsr_checker.sv @@
// Port-level checker for the LED status ring renderer, bound to the top.
// Depends on lrsr_pkg and led_ring_status_renderer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "led_ring_status_renderer_assert.svh"

module lrsr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_cmd,
  input logic                out_valid,
  input logic                out_ready,
  input lrsr_pkg::out_item_t out_item
);

  // a status tick blocks the input until its work is done
  `LRSR_ASSERT_NXT(a_tick_busy, in_valid && in_ready && in_cmd == lrsr_pkg::CMD_TICK, !in_ready, "input still ready after a status tick")

  // no new item while a frame is only partly sent
  `LRSR_ASSERT_IMP(a_frame_blocks, out_valid && !out_item.last_led, !in_ready, "input ready in the middle of a frame")

  // beats of a frame follow back to back in index order
  `LRSR_ASSERT_NXT(a_led_order, out_valid && out_ready && !out_item.last_led, out_valid && out_item.led_index == $past(out_item.led_index) + 4'd1, "frame beat missing or out of order")

  // hold a stalled beat
  `LRSR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result beat changed")

endmodule

bind led_ring_status_renderer lrsr_checker u_lrsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_cmd    (in_if.payload.cmd),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_item  (out_if.payload)
);

`default_nettype wire

@@ tb/lrsr_ring_checker.sv @@
// LED ring renderer checker: watches the input, config and LED channels,
// predicts every LED beat and compares it. Depends on lrsr_pkg and lrsr_if.sv.
`timescale 1ns / 1ps

module lrsr_ring_checker
  import lrsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lrsr_in_if          in_mon,
  lrsr_out_if         out_mon,
  lrsr_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned beats_pending
);

  cfg_regs_t   regs;
  logic [1:0]  flash_kind;
  logic [31:0] flash_t0;
  logic [5:0]  face_minute;
  logic        face_minute_ok;
  logic        face_dirty;
  logic [23:0] held_rgb;
  logic [7:0]  held_bright;
  logic        solid_held;
  logic [3:0]  held_bar;
  logic        bar_held;

  logic [23:0] frame_rgb [RING_LEDS];
  out_item_t   led_expect_q [$];

  int unsigned errs = 0;
  int unsigned pend = 0;

  assign fail_count    = errs;
  assign beats_pending = pend;

  task automatic clear_state();
    regs.global_brightness = RST_BRIGHTNESS;
    regs.alarm_color       = 24'hFF0000;
    regs.alarm_on_time     = 16'd250;
    regs.alarm_off_time    = 16'd250;
    regs.grace_color       = 24'hFFC800;
    regs.motion_color      = 24'h00FF00;
    regs.timer_color       = 24'h00B4FF;
    regs.radio_color       = 24'hFFFFFF;
    flash_kind     = CAUSE_NONE;
    flash_t0       = '0;
    face_minute    = '0;
    face_minute_ok = 1'b0;
    face_dirty     = 1'b1;
    held_rgb       = RGB_BLACK;
    held_bright    = RST_BRIGHTNESS;
    solid_held     = 1'b1;
    held_bar       = '0;
    bar_held       = 1'b0;
    led_expect_q.delete();
  endtask

  function automatic logic [7:0] quiet_level(input logic [7:0] c);
    logic [15:0] p;
    p = c * 16'd48;
    return (c == 8'd0) ? 8'd0 : p[15:8] + 8'd1;
  endfunction

  function automatic logic [3:0] bar_length(input logic [7:0] prog);
    int n;
    n = 1 + (int'(prog) * 11) / 255;
    return n[3:0];
  endfunction

  task automatic push_frame();
    out_item_t b;
    for (int i = 0; i < RING_LEDS; i++) begin
      b.led_index  = 4'(i);
      b.red        = frame_rgb[i][23:16];
      b.green      = frame_rgb[i][15:8];
      b.blue       = frame_rgb[i][7:0];
      b.brightness = regs.global_brightness;
      b.last_led   = (i == RING_LEDS - 1);
      led_expect_q.push_back(b);
    end
  endtask

  task automatic paint_solid(input logic [23:0] rgb);
    if (solid_held && rgb == held_rgb && regs.global_brightness == held_bright) begin
      return;
    end
    for (int i = 0; i < RING_LEDS; i++) frame_rgb[i] = rgb;
    held_rgb    = rgb;
    held_bright = regs.global_brightness;
    solid_held  = 1'b1;
    bar_held    = 1'b0;
    push_frame();
  endtask

  task automatic paint_bar(input logic [23:0] rgb, input logic [3:0] lit);
    if (bar_held && held_bar == lit && rgb == held_rgb &&
        regs.global_brightness == held_bright) begin
      return;
    end
    // lit LEDs run clockwise from the top, i.e. downward from index 11
    for (int i = 0; i < RING_LEDS; i++) begin
      frame_rgb[i] = (i >= RING_LEDS - int'(lit)) ? rgb : RGB_BLACK;
    end
    held_bar    = lit;
    bar_held    = 1'b1;
    held_rgb    = rgb;
    held_bright = regs.global_brightness;
    solid_held  = 1'b0;
    push_frame();
  endtask

  task automatic paint_face(input logic [4:0] hour, input logic [5:0] minute);
    int hp;
    int mb;
    int mp;
    hp = 11 - (int'(hour) % 12);
    mb = int'(minute) / 5;
    if (mb > 11) mb = 11;
    mp = 11 - mb;
    for (int i = 0; i < RING_LEDS; i++) frame_rgb[i] = RGB_BLACK;
    if (hp == mp) begin
      frame_rgb[hp] = RGB_SHARED;
    end else begin
      frame_rgb[hp] = RGB_HOUR;
      frame_rgb[mp] = RGB_MINUTE;
    end
    solid_held = 1'b0;
    bar_held   = 1'b0;
    push_frame();
  endtask

  task automatic apply_cfg(input cfg_write_t w);
    case (w.index)
      REG_BRIGHTNESS: regs.global_brightness = w.data[7:0];
      REG_ALARM_RGB:  regs.alarm_color       = w.data;
      REG_ALARM_ON:   regs.alarm_on_time     = w.data[15:0];
      REG_ALARM_OFF:  regs.alarm_off_time    = w.data[15:0];
      REG_GRACE_RGB:  regs.grace_color       = w.data;
      REG_MOTION_RGB: regs.motion_color      = w.data;
      REG_TIMER_RGB:  regs.timer_color       = w.data;
      REG_RADIO_RGB:  regs.radio_color       = w.data;
      default:        return;
    endcase
    solid_held = 1'b0;
  endtask

  task automatic predict_tick(input in_item_t it);
    logic [23:0] col;
    logic [31:0] elapsed;
    logic [31:0] period;
    logic [31:0] phase;
    if (it.cmd == CMD_WAKE) begin
      if (it.wake_cause != CAUSE_NONE) begin
        flash_kind = it.wake_cause;
        flash_t0   = it.now_ms;
      end
      return;
    end
    elapsed = it.now_ms - flash_t0;
    if (flash_kind != CAUSE_NONE && elapsed >= FLASH_TIME_MS) flash_kind = CAUSE_NONE;

    if (it.unpaired) begin
      face_dirty = 1'b1;
      paint_solid(RGB_BLACK);
    end else if (it.enforcing && !it.cond_ok) begin
      col = regs.alarm_color;
      face_dirty = 1'b1;
      if (!it.burst_on) begin
        col = {quiet_level(col[23:16]), quiet_level(col[15:8]), quiet_level(col[7:0])};
      end else if (regs.alarm_on_time != 16'd0 && regs.alarm_off_time != 16'd0) begin
        period  = {16'd0, regs.alarm_on_time} + {16'd0, regs.alarm_off_time};
        elapsed = it.now_ms - it.output_since;
        phase   = elapsed % period;
        if (phase >= {16'd0, regs.alarm_on_time}) col = RGB_BLACK;
      end
      paint_solid(col);
    end else if (it.enforcing && it.cond_ok && it.grace_open) begin
      face_dirty = 1'b1;
      paint_bar(regs.grace_color, bar_length(it.grace_progress));
    end else if (flash_kind != CAUSE_NONE) begin
      case (flash_kind)
        CAUSE_MOTION: col = regs.motion_color;
        CAUSE_TIMER:  col = regs.timer_color;
        default:      col = regs.radio_color;
      endcase
      face_dirty = 1'b1;
      paint_solid(col);
    end else if (it.enforcing) begin
      face_dirty = 1'b1;
    end else if (face_dirty || !face_minute_ok || it.minute_of_hour != face_minute) begin
      paint_face(it.hour_of_day, it.minute_of_hour);
      face_minute    = it.minute_of_hour;
      face_minute_ok = 1'b1;
      face_dirty     = 1'b0;
    end
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (led_expect_q.size() == 0) begin
      $display("%0t: unexpected LED beat idx %0d rgb %02h%02h%02h br %0d last %0b",
               $time, got.led_index, got.red, got.green, got.blue, got.brightness,
               got.last_led);
      errs++;
      return;
    end
    want = led_expect_q.pop_front();
    if (got.led_index !== want.led_index || got.red !== want.red ||
        got.green !== want.green || got.blue !== want.blue ||
        got.brightness !== want.brightness || got.last_led !== want.last_led) begin
      $display("%0t: LED beat mismatch, expected idx %0d rgb %02h%02h%02h br %0d last %0b,%s",
               $time, want.led_index, want.red, want.green, want.blue, want.brightness,
               want.last_led, " got");
      $display("%0t:   actual idx %0d rgb %02h%02h%02h br %0d last %0b",
               $time, got.led_index, got.red, got.green, got.blue, got.brightness,
               got.last_led);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      // beats out belong to earlier ticks, so check them before predicting
      if (out_mon.valid && out_mon.ready) check_beat(out_mon.payload);
      if (cfg_mon.valid && cfg_mon.ready) apply_cfg(cfg_mon.payload);
      if (in_mon.valid && in_mon.ready) predict_tick(in_mon.payload);
    end
    pend = led_expect_q.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the LED ring renderer: clock, reset, stimulus, config
// phases and verdict. Depends on lrsr_pkg, lrsr_if.sv and lrsr_ring_checker.
`timescale 1ns / 1ps

module tb;
  import lrsr_pkg::*;

  // {unpaired, enforcing, cond_ok, grace_open, burst_on}
  localparam logic [4:0] MODE_CLOCK      = 5'b00000;
  localparam logic [4:0] MODE_DARK       = 5'b10000;
  localparam logic [4:0] MODE_ALARM_IDLE = 5'b01000;
  localparam logic [4:0] MODE_ALARM      = 5'b01001;
  localparam logic [4:0] MODE_GRACE      = 5'b01110;
  localparam logic [4:0] MODE_HOLD       = 5'b01100;

  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst_n;

  lrsr_in_if  in_if ();
  lrsr_out_if out_if ();
  lrsr_cfg_if cfg_if ();

  int unsigned chk_fails;
  int unsigned chk_pending;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  logic [31:0] wall_ms;
  logic [4:0]  wall_hour;
  logic [5:0]  wall_min;
  logic [7:0]  last_prog;

  always #10 clk = ~clk;

  led_ring_status_renderer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  lrsr_ring_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .fail_count    (chk_fails),
    .beats_pending (chk_pending)
  );

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  function automatic in_item_t ring_tick(input logic [31:0] now, input logic [4:0] mode,
                                         input logic [31:0] since, input logic [7:0] prog,
                                         input logic [4:0] hour, input logic [5:0] minute);
    in_item_t it;
    it = '0;
    it.cmd = CMD_TICK;
    it.now_ms = now;
    {it.unpaired, it.enforcing, it.cond_ok, it.grace_open, it.burst_on} = mode;
    it.output_since = since;
    it.grace_progress = prog;
    it.hour_of_day = hour;
    it.minute_of_hour = minute;
    return it;
  endfunction

  function automatic in_item_t wake_note(input logic [31:0] now, input logic [1:0] cause);
    in_item_t it;
    it = '0;
    it.cmd = CMD_WAKE;
    it.now_ms = now;
    it.wake_cause = cause;
    return it;
  endfunction

  // Entered and left at a falling edge; valid stays up when no gap follows.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= {idx, data};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold the sender until every LED beat is out, then let the block go quiet.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_setting(input int which);
    case (which)
      0: begin
        write_reg(REG_BRIGHTNESS, 24'h0000FF);
        write_reg(REG_ALARM_RGB,  24'hFFFFFF);
        write_reg(REG_ALARM_ON,   24'h000000);
        write_reg(REG_ALARM_OFF,  24'h0000FA);
        write_reg(REG_GRACE_RGB,  24'h000000);
        write_reg(REG_MOTION_RGB, 24'hFFFFFF);
        write_reg(REG_TIMER_RGB,  24'h000000);
        write_reg(REG_RADIO_RGB,  24'h010101);
        write_reg(4'd9,           24'hABCDEF);
      end
      1: begin
        write_reg(REG_BRIGHTNESS, 24'hFFFF00);
        write_reg(REG_ALARM_RGB,  24'h000001);
        write_reg(REG_ALARM_ON,   24'h000001);
        write_reg(REG_ALARM_OFF,  24'h000000);
        write_reg(REG_GRACE_RGB,  24'hFFFFFF);
        write_reg(REG_MOTION_RGB, 24'h000000);
        write_reg(REG_TIMER_RGB,  24'hFFFFFF);
        write_reg(REG_RADIO_RGB,  24'h000000);
        write_reg(4'd15,          24'h123456);
      end
      2: begin
        write_reg(REG_BRIGHTNESS, 24'($urandom()));
        write_reg(REG_ALARM_RGB,  24'($urandom()));
        write_reg(REG_ALARM_ON,   24'hFFFFFF);
        write_reg(REG_ALARM_OFF,  24'h00FFFF);
        write_reg(REG_GRACE_RGB,  24'($urandom()));
        write_reg(REG_MOTION_RGB, 24'($urandom()));
        write_reg(REG_TIMER_RGB,  24'($urandom()));
        write_reg(REG_RADIO_RGB,  24'($urandom()));
      end
      default: begin
        write_reg(REG_BRIGHTNESS, 24'($urandom()));
        write_reg(REG_ALARM_RGB,  24'($urandom()));
        write_reg(REG_ALARM_ON,   24'($urandom_range(1, 600)));
        write_reg(REG_ALARM_OFF,  24'($urandom_range(1, 600)));
        write_reg(REG_GRACE_RGB,  24'($urandom()));
        write_reg(REG_MOTION_RGB, 24'($urandom()));
        write_reg(REG_TIMER_RGB,  24'($urandom()));
        write_reg(REG_RADIO_RGB,  24'($urandom()));
      end
    endcase
  endtask

  task automatic random_item(output in_item_t it);
    int unsigned sel;
    if ($urandom_range(0, 99) < 4) wall_ms = $urandom();
    else wall_ms = wall_ms + $urandom_range(0, 400);
    // mostly keep the minute so the face cache gets hit
    if ($urandom_range(0, 9) < 4) begin
      wall_min = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                             : 6'($urandom_range(0, 59));
      wall_hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                              : 5'($urandom_range(0, 23));
    end
    it.cmd            = CMD_TICK;
    it.now_ms         = wall_ms;
    it.wake_cause     = 2'($urandom_range(0, 3));
    it.unpaired       = 1'($urandom_range(0, 1));
    it.enforcing      = 1'($urandom_range(0, 1));
    it.cond_ok        = 1'($urandom_range(0, 1));
    it.grace_open     = 1'($urandom_range(0, 1));
    it.burst_on       = 1'($urandom_range(0, 1));
    it.output_since   = $urandom();
    it.grace_progress = 8'($urandom_range(0, 255));
    it.hour_of_day    = wall_hour;
    it.minute_of_hour = wall_min;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      it.cmd = CMD_WAKE;
    end else if (sel < 22) begin
      it.unpaired = 1'b1;
    end else if (sel < 45) begin
      {it.unpaired, it.enforcing, it.cond_ok} = 3'b010;
      it.burst_on = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 3) != 0) it.output_since = wall_ms - $urandom_range(0, 1500);
    end else if (sel < 65) begin
      {it.unpaired, it.enforcing, it.cond_ok, it.grace_open} = 4'b0111;
      if ($urandom_range(0, 2) == 0) it.grace_progress = last_prog;
      last_prog = it.grace_progress;
    end else if (sel < 75) begin
      {it.unpaired, it.enforcing, it.cond_ok, it.grace_open} = 4'b0110;
    end else begin
      {it.unpaired, it.enforcing} = 2'b00;
    end
  endtask

  task automatic run_random(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      random_item(it);
      send_item(it);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    out_if.ready   = 1'b0;
    wall_ms        = 32'h0000_1000;
    wall_hour      = 5'd0;
    wall_min       = 6'd0;
    last_prog      = 8'd0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: face, caches, alarm forms, bar ends, flashes and wraps
    send_item(ring_tick(32'd1000, MODE_CLOCK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd1100, MODE_CLOCK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd1200, MODE_CLOCK, 32'd0, 8'd0, 5'd23, 6'd59));
    send_item(ring_tick(32'd1300, MODE_CLOCK, 32'd0, 8'd0, 5'd31, 6'd63));
    send_item(ring_tick(32'd1400, MODE_DARK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd1500, MODE_ALARM_IDLE, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd1600, MODE_ALARM, 32'd1600, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd1700, MODE_ALARM, 32'd1400, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd1800, MODE_ALARM, 32'hFFFF_FF00, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd1900, MODE_GRACE, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd2000, MODE_GRACE, 32'd0, 8'd255, 5'd0, 6'd0));
    send_item(ring_tick(32'd2100, MODE_GRACE, 32'd0, 8'd128, 5'd0, 6'd0));
    send_item(ring_tick(32'd2200, MODE_GRACE, 32'd0, 8'd128, 5'd0, 6'd0));
    send_item(wake_note(32'd2300, CAUSE_NONE));
    send_item(wake_note(32'd2400, CAUSE_MOTION));
    send_item(ring_tick(32'd2500, MODE_CLOCK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd2999, MODE_CLOCK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'd3000, MODE_CLOCK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(wake_note(32'd3100, CAUSE_TIMER));
    send_item(ring_tick(32'd3200, MODE_HOLD, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(wake_note(32'hFFFF_FF00, CAUSE_RADIO));
    send_item(ring_tick(32'h0000_00A0, MODE_CLOCK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'h0000_0400, MODE_HOLD, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'h0000_0500, MODE_CLOCK, 32'd0, 8'd0, 5'd0, 6'd0));
    send_item(ring_tick(32'hFFFF_FFFF, MODE_DARK, 32'd0, 8'd0, 5'd0, 6'd0));

    run_random(20);

    drain();
    load_setting(0);
    tx_idle_pct = 65;
    run_random(20);

    drain();
    load_setting(1);
    tx_idle_pct  = 0;
    rx_stall_pct = 65;
    run_random(20);

    drain();
    load_setting(2);
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    run_random(20);

    drain();
    load_setting(3);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_random(10);
    tx_idle_pct  = 20;
    rx_stall_pct = 65;
    run_random(10);

    drain();
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
